// ===== rtl/core/dobd_pkg.sv =====
// shared constants and types of the detector box decoder
`timescale 1ns / 1ps

package dobd_pkg;

   localparam int GEOM_WORDS  = 4;
   localparam int MAX_CLASSES = 128;
   localparam int WORD_W      = 16;
   localparam int POS_W       = 8;
   localparam int BOX_W       = 16;
   localparam int CLASS_W     = 8;
   localparam int COORD_W     = 16;
   localparam int SIZE_W      = 15;
   localparam int PAD_W       = 12;
   localparam int SCALE_W     = 24;
   localparam int MASK_W      = 64;
   localparam int DIFF_MAG_W  = 18;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_COUNT     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCORE_THRESHOLD = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_LEFT        = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_TOP         = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERSE_SCALE   = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_MASK_LOW  = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_MASK_HIGH = 8'd6;

   // a kept box on its way to the pixel mapping stages
   typedef struct packed {
      logic [BOX_W-1:0]        box_number;
      logic signed [CLASS_W-1:0] class_id;
      logic [WORD_W-1:0]       best_score;
      logic                    left_neg;
      logic [DIFF_MAG_W-1:0]   left_mag;
      logic                    top_neg;
      logic [DIFF_MAG_W-1:0]   top_mag;
      logic [WORD_W-1:0]       width_raw;
      logic [WORD_W-1:0]       height_raw;
   } box_type;

endpackage

// ===== rtl/core/dobd_req_if.sv =====
// input word channel of the detector box decoder
`timescale 1ns / 1ps

interface dobd_req_if;
   import dobd_pkg::*;

   logic              valid;
   logic              ready;
   logic              start_of_box;
   logic [WORD_W-1:0] word_value;

   modport source (output valid, start_of_box, word_value, input ready);
   modport sink   (input valid, start_of_box, word_value, output ready);
endinterface

// ===== rtl/core/dobd_rsp_if.sv =====
// result channel of the detector box decoder
`timescale 1ns / 1ps

interface dobd_rsp_if;
   import dobd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [BOX_W-1:0]          box_number;
   logic signed [CLASS_W-1:0] class_id;
   logic [WORD_W-1:0]         best_score;
   logic signed [COORD_W-1:0] left;
   logic signed [COORD_W-1:0] top;
   logic [SIZE_W-1:0]         box_width;
   logic [SIZE_W-1:0]         box_height;

   modport source (output valid, box_number, class_id, best_score, left, top,
                   box_width, box_height, input ready);
   modport sink   (input valid, box_number, class_id, best_score, left, top,
                   box_width, box_height, output ready);
endinterface

// ===== rtl/core/dobd_csr_if.sv =====
// register write channel of the detector box decoder
`timescale 1ns / 1ps

interface dobd_csr_if;
   import dobd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dobd_map.sv =====
// pixel mapping stages: scale multiply, truncate, saturate, result register
`timescale 1ns / 1ps

module dobd_map (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         box_valid,
   input  dobd_pkg::box_type            box_in,
   input  logic [dobd_pkg::SCALE_W-1:0] inverse_scale,
   output logic                         advance,
   dobd_rsp_if.source                   rsp
);
   import dobd_pkg::*;

   localparam int CORNER_PROD_W = DIFF_MAG_W + SCALE_W;
   localparam int SIZE_PROD_W   = WORD_W + SCALE_W;
   localparam int CORNER_SHIFT  = 21;
   localparam int SIZE_SHIFT    = 20;
   localparam int CORNER_Q_W    = CORNER_PROD_W - CORNER_SHIFT;
   localparam int SIZE_Q_W      = SIZE_PROD_W - SIZE_SHIFT;

   logic                      mul_valid_ff;
   logic [BOX_W-1:0]          mul_box_number_ff;
   logic signed [CLASS_W-1:0] mul_class_ff;
   logic [WORD_W-1:0]         mul_score_ff;
   logic                      mul_left_neg_ff;
   logic                      mul_top_neg_ff;
   logic [CORNER_PROD_W-1:0]  mul_left_ff;
   logic [CORNER_PROD_W-1:0]  mul_top_ff;
   logic [SIZE_PROD_W-1:0]    mul_width_ff;
   logic [SIZE_PROD_W-1:0]    mul_height_ff;

   logic                      rsp_valid_ff;
   logic [BOX_W-1:0]          rsp_box_number_ff;
   logic signed [CLASS_W-1:0] rsp_class_ff;
   logic [WORD_W-1:0]         rsp_score_ff;
   logic signed [COORD_W-1:0] rsp_left_ff;
   logic signed [COORD_W-1:0] rsp_top_ff;
   logic [SIZE_W-1:0]         rsp_width_ff;
   logic [SIZE_W-1:0]         rsp_height_ff;

   logic                      mul_advance;
   logic                      rsp_advance;

   // truncated magnitude back to a signed coordinate, clamped to 16 bits
   function automatic logic signed [COORD_W-1:0] corner_sat(
      input logic                  neg,
      input logic [CORNER_Q_W-1:0] q
   );
      logic signed [COORD_W-1:0] res;
      if (neg) begin
         if (q >= CORNER_Q_W'(32768)) begin
            res = 16'sh8000;
         end else begin
            res = COORD_W'(16'd0 - {1'b0, q[SIZE_W-1:0]});
         end
      end else begin
         if (q > CORNER_Q_W'(32767)) begin
            res = 16'sh7FFF;
         end else begin
            res = {1'b0, q[SIZE_W-1:0]};
         end
      end
      return res;
   endfunction

   function automatic logic [SIZE_W-1:0] size_sat(input logic [SIZE_Q_W-1:0] q);
      logic [SIZE_W-1:0] res;
      if (q > SIZE_Q_W'(32767)) begin
         res = '1;
      end else begin
         res = q[SIZE_W-1:0];
      end
      return res;
   endfunction

   // each stage moves when it is empty or the stage after it moves
   assign rsp_advance = !rsp_valid_ff || rsp.ready;
   assign mul_advance = !mul_valid_ff || rsp_advance;
   assign advance     = !box_valid || mul_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (mul_advance) begin
            mul_valid_ff <= box_valid;
         end
         if (rsp_advance) begin
            rsp_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_advance) begin
         mul_box_number_ff <= box_in.box_number;
         mul_class_ff      <= box_in.class_id;
         mul_score_ff      <= box_in.best_score;
         mul_left_neg_ff   <= box_in.left_neg;
         mul_top_neg_ff    <= box_in.top_neg;
         mul_left_ff       <= CORNER_PROD_W'(box_in.left_mag) * CORNER_PROD_W'(inverse_scale);
         mul_top_ff        <= CORNER_PROD_W'(box_in.top_mag) * CORNER_PROD_W'(inverse_scale);
         mul_width_ff      <= SIZE_PROD_W'(box_in.width_raw) * SIZE_PROD_W'(inverse_scale);
         mul_height_ff     <= SIZE_PROD_W'(box_in.height_raw) * SIZE_PROD_W'(inverse_scale);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_advance) begin
         rsp_box_number_ff <= mul_box_number_ff;
         rsp_class_ff      <= mul_class_ff;
         rsp_score_ff      <= mul_score_ff;
         rsp_left_ff       <= corner_sat(mul_left_neg_ff,
                                         mul_left_ff[CORNER_PROD_W-1:CORNER_SHIFT]);
         rsp_top_ff        <= corner_sat(mul_top_neg_ff,
                                         mul_top_ff[CORNER_PROD_W-1:CORNER_SHIFT]);
         rsp_width_ff      <= size_sat(mul_width_ff[SIZE_PROD_W-1:SIZE_SHIFT]);
         rsp_height_ff     <= size_sat(mul_height_ff[SIZE_PROD_W-1:SIZE_SHIFT]);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.box_number = rsp_box_number_ff;
   assign rsp.class_id   = rsp_class_ff;
   assign rsp.best_score = rsp_score_ff;
   assign rsp.left       = rsp_left_ff;
   assign rsp.top        = rsp_top_ff;
   assign rsp.box_width  = rsp_width_ff;
   assign rsp.box_height = rsp_height_ff;

endmodule

// ===== rtl/core/detector_output_box_decode_unit.sv =====
// top level of the detector box decoder: word tracking, argmax, box filter
`timescale 1ns / 1ps

// Takes one output word per cycle (four geometry words, then class_count
// score words per box) with no gaps of its own: the argmax compare and the
// keep decision for each word fit in the cycle in which it is accepted. A
// kept box passes from its last score word through a decision
// register, a register behind the scale multipliers and the result register;
// dropped boxes give no transaction. The input stalls only while a result
// waits in the output register and the pipeline behind it is full.
// Registers are written through the csr channel, which is always ready, and
// should be changed only while no box is in flight.
module detector_output_box_decode_unit (
   input  logic       clock,
   input  logic       reset,
   dobd_req_if.sink   req,
   dobd_rsp_if.source rsp,
   dobd_csr_if.sink   csr
);
   import dobd_pkg::*;

   logic [CLASS_W-1:0] class_count_ff;
   logic [WORD_W-1:0]  score_threshold_ff;
   logic [PAD_W-1:0]   pad_left_ff;
   logic [PAD_W-1:0]   pad_top_ff;
   logic [SCALE_W-1:0] inverse_scale_ff;
   logic [MASK_W-1:0]  class_mask_low_ff;
   logic [MASK_W-1:0]  class_mask_high_ff;

   logic [POS_W-1:0]          position_ff;
   logic [POS_W-1:0]          position_in;
   logic [BOX_W-1:0]          box_counter_ff;
   logic [WORD_W-1:0]         geometry_ff [GEOM_WORDS];
   logic [WORD_W-1:0]         best_score_ff;
   logic [WORD_W-1:0]         best_score_in;
   logic signed [CLASS_W-1:0] best_class_ff;
   logic signed [CLASS_W-1:0] best_class_in;

   logic                      box_valid_ff;
   box_type                   box_ff;
   box_type                   box_in;

   logic                      advance;
   logic                      req_fire;
   logic                      csr_fire;
   logic [POS_W-1:0]          pos_base;
   logic [POS_W-1:0]          eff_classes;
   logic [POS_W-1:0]          last_index;
   logic [WORD_W-1:0]         base_score;
   logic signed [CLASS_W-1:0] base_class;
   logic                      score_wins;
   logic                      record_done;
   logic                      class_ok;
   logic                      keep;
   logic [2*MASK_W-1:0]       mask_all;
   logic signed [DIFF_MAG_W:0] left_diff;
   logic signed [DIFF_MAG_W:0] top_diff;

   assign req_fire  = req.valid && req.ready;
   assign csr_fire  = csr.valid && csr.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff     <= 8'd80;
         score_threshold_ff <= 16'd16384;
         pad_left_ff        <= '0;
         pad_top_ff         <= '0;
         inverse_scale_ff   <= 24'd65536;
         class_mask_low_ff  <= '1;
         class_mask_high_ff <= '1;
      end else if (csr_fire) begin
         unique case (csr.index)
            REG_CLASS_COUNT:     class_count_ff     <= csr.data[CLASS_W-1:0];
            REG_SCORE_THRESHOLD: score_threshold_ff <= csr.data[WORD_W-1:0];
            REG_PAD_LEFT:        pad_left_ff        <= csr.data[PAD_W-1:0];
            REG_PAD_TOP:         pad_top_ff         <= csr.data[PAD_W-1:0];
            REG_INVERSE_SCALE:   inverse_scale_ff   <= csr.data[SCALE_W-1:0];
            REG_CLASS_MASK_LOW:  class_mask_low_ff  <= csr.data[MASK_W-1:0];
            REG_CLASS_MASK_HIGH: class_mask_high_ff <= csr.data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (class_count_ff == '0) begin
         eff_classes = POS_W'(1);
      end else if (class_count_ff > CLASS_W'(MAX_CLASSES)) begin
         eff_classes = POS_W'(MAX_CLASSES);
      end else begin
         eff_classes = class_count_ff;
      end
   end

   assign last_index = eff_classes + POS_W'(GEOM_WORDS - 1);

   // a start mark restarts the record wherever it falls
   assign pos_base    = req.start_of_box ? '0 : position_ff;
   assign record_done = pos_base >= last_index;
   assign base_score  = (pos_base == '0) ? '0 : best_score_ff;
   assign base_class  = (pos_base == '0) ? -8'sd1 : best_class_ff;
   assign score_wins  = (pos_base >= POS_W'(GEOM_WORDS)) && (req.word_value > base_score);

   always_comb begin
      if (score_wins) begin
         best_score_in = req.word_value;
         best_class_in = CLASS_W'(pos_base - POS_W'(GEOM_WORDS));
      end else begin
         best_score_in = base_score;
         best_class_in = base_class;
      end
   end

   assign position_in = record_done ? '0 : pos_base + POS_W'(1);

   assign mask_all = {class_mask_high_ff, class_mask_low_ff};
   assign class_ok = best_class_in[CLASS_W-1] ? (&mask_all)
                                              : mask_all[best_class_in[CLASS_W-2:0]];
   assign keep     = record_done && (best_score_in >= score_threshold_ff) && class_ok;

   // corner offsets in half network pixels of Q.4, i.e. Q.5
   assign left_diff = $signed({2'b00, geometry_ff[0], 1'b0})
                    - $signed({3'b000, geometry_ff[2]})
                    - $signed({2'b00, pad_left_ff, 5'b00000});
   assign top_diff  = $signed({2'b00, geometry_ff[1], 1'b0})
                    - $signed({3'b000, geometry_ff[3]})
                    - $signed({2'b00, pad_top_ff, 5'b00000});

   always_comb begin
      box_in.box_number = box_counter_ff;
      box_in.class_id   = best_class_in;
      box_in.best_score = best_score_in;
      box_in.left_neg   = left_diff[DIFF_MAG_W];
      box_in.left_mag   = left_diff[DIFF_MAG_W] ? DIFF_MAG_W'(-left_diff)
                                                : left_diff[DIFF_MAG_W-1:0];
      box_in.top_neg    = top_diff[DIFF_MAG_W];
      box_in.top_mag    = top_diff[DIFF_MAG_W] ? DIFF_MAG_W'(-top_diff)
                                               : top_diff[DIFF_MAG_W-1:0];
      box_in.width_raw  = geometry_ff[2];
      box_in.height_raw = geometry_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         box_counter_ff <= '0;
         best_score_ff  <= '0;
         best_class_ff  <= -8'sd1;
         for (int i = 0; i < GEOM_WORDS; i++) begin
            geometry_ff[i] <= '0;
         end
      end else if (req_fire) begin
         position_ff   <= position_in;
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
         if (pos_base < POS_W'(GEOM_WORDS)) begin
            geometry_ff[pos_base[1:0]] <= req.word_value;
         end
         if (record_done) begin
            box_counter_ff <= box_counter_ff + BOX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_valid_ff <= 1'b0;
      end else if (advance) begin
         box_valid_ff <= req_fire && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         box_ff <= box_in;
      end
   end

   dobd_map u_map (
      .clock         (clock),
      .reset         (reset),
      .box_valid     (box_valid_ff),
      .box_in        (box_ff),
      .inverse_scale (inverse_scale_ff),
      .advance       (advance),
      .rsp           (rsp)
   );

`ifndef SYNTHESIS
   a_counter_steps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && record_done) |=> (box_counter_ff == $past(box_counter_ff) + BOX_W'(1)))
      else $error("box counter did not step on a completed record");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !req.ready |=> ($stable(box_counter_ff) && $stable(position_ff)))
      else $error("record state changed while input stalled");

   a_class_has_score: assert property (@(posedge clock) disable iff (reset)
      !best_class_ff[CLASS_W-1] |-> (best_score_ff != '0))
      else $error("class chosen without a positive score");

   // a pending box was either just decided or is held by a stall
   a_keep_needs_done: assert property (@(posedge clock) disable iff (reset)
      box_valid_ff |-> $past(req_fire || (box_valid_ff && !advance)))
      else $error("box issued without an accepted word");
`endif

endmodule
